// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/pga_pkg.sv =====
// ----------------------------------------------------------------------------
// pga_pkg
// Shared types and register codes of the pairwise gravity acceleration block.
// ----------------------------------------------------------------------------
`default_nettype none

package pga_pkg;

  // Configuration register indexes.
  typedef enum logic {
    REG_GRAVITY   = 1'b0,
    REG_SOFTENING = 1'b1
  } reg_index_t;

  localparam int CFG_W = 32;

  // One pair to evaluate.
  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic signed [31:0] source_z;
    logic [31:0]        source_mass;
    logic               same_particle;
  } in_item_t;

  // Acceleration on the target.
  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/pairwise_gravity_acceleration_top.sv =====
// ----------------------------------------------------------------------------
// pairwise_gravity_acceleration_top
// Softened gravitational acceleration of one source particle on one target.
// ----------------------------------------------------------------------------
// The block takes one pair per clock unless its output buffer is full, and
// returns one acceleration vector per pair, in order. Each pair passes through
// 75 register stages: the difference, multiply and sum stages, 34 square-root
// bit steps, three stages for the cube of the distance, the divider entry
// stage, 33 quotient-bit steps shared by the three axis dividers, and the
// output register. A two-entry output buffer lets the pipeline keep running
// while one finished result waits; the whole pipeline holds only while both
// entries are full, including the cycle in which the second entry moves into
// the first.
`default_nettype none
`include "assert_macros.svh"

module pairwise_gravity_acceleration_top
  import pga_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  // Datapath widths.
  localparam int DW   = 33;              // axis difference magnitude
  localparam int SQW  = 2 * DW;          // squared difference
  localparam int RW   = SQW + 1;         // softened r^2
  localparam int QW   = 34;              // floor(sqrt(r^2))
  localparam int Q2W  = 2 * QW;
  localparam int DENW = 3 * QW;          // q^3
  localparam int GMW  = 64;              // G * m
  localparam int PLW  = GMW / 2 + DW;    // half-width partial product
  localparam int PRW  = GMW + DW;        // G * m * |D|
  localparam int NUMW = PRW + FRAC_BITS; // shifted numerator
  localparam int QUW  = 33;              // quotient bits kept
  localparam int WW   = DENW + QUW + 1;  // divider compare width

  // Stage numbering.
  localparam int SS0 = 3;
  localparam int SQ1 = SS0 + QW;
  localparam int SD0 = SQ1 + 3;
  localparam int NST = SD0 + QUW + 1;

  localparam logic [CFG_W-1:0] SOFT_RESET = CFG_W'((64'd1 << FRAC_BITS) / 100);

  typedef struct packed {
    logic                 kill;
    logic [2:0]           neg;
    logic [2:0][NUMW-1:0] num;
  } carry_t;

  typedef struct packed {
    logic [2:0][DW-1:0] mag;
    logic [2:0]         neg;
    logic [GMW-1:0]     gm;
    logic               same;
  } st_a_t;

  typedef struct packed {
    logic [2:0][SQW-1:0] sq;
    logic [2:0][PLW-1:0] pl;
    logic [2:0][PLW-1:0] ph;
    logic [2:0]          neg;
    logic                same;
  } st_b_t;

  typedef struct packed {
    logic [RW-1:0] r2;
    carry_t        cy;
  } st_c_t;

  typedef struct packed {
    logic [QW-1:0] res;
    logic [RW-1:0] rem;
    carry_t        cy;
  } st_s_t;

  typedef struct packed {
    logic [QW-1:0]  q;
    logic [Q2W-1:0] q2;
    carry_t         cy;
  } st_q1_t;

  typedef struct packed {
    logic [Q2W-1:0] p_lo;
    logic [Q2W-1:0] p_hi;
    carry_t         cy;
  } st_q2_t;

  typedef struct packed {
    logic [DENW-1:0] den;
    carry_t          cy;
  } st_q3_t;

  typedef struct packed {
    logic [2:0][WW-1:0]  rem;
    logic [2:0][QUW-1:0] quo;
    logic [2:0]          ovf;
    logic [DENW-1:0]     den;
    logic                kill;
    logic [2:0]          neg;
  } st_d_t;

  logic [CFG_W-1:0] gravity;
  logic [CFG_W-1:0] softening;
  logic [NST-1:0]   vld;
  logic             en;

  st_a_t  sa, sa_next;
  st_b_t  sb, sb_next;
  st_c_t  sc, sc_next;
  st_s_t  ss_first;
  st_s_t  ss_reg [QW];
  st_q1_t sq1, sq1_next;
  st_q2_t sq2, sq2_next;
  st_q3_t sq3;
  st_d_t  dv_first;
  st_d_t  dv_reg [QUW+1];

  out_item_t res_item;
  logic      ov, sv;
  out_item_t od, sd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity   <= '0;
      softening <= SOFT_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_GRAVITY:   gravity   <= cfg_data;
        REG_SOFTENING: softening <= cfg_data;
        default:       gravity   <= gravity;
      endcase
    end
  end

  // The pipeline moves as one; it holds only while the skid entry is full.
  assign en       = !sv;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // Stage A: differences, their magnitudes and G * m.
  always_comb begin
    logic [31:0] tgt [3];
    logic [31:0] src [3];
    logic [DW-1:0] d;
    tgt[0] = in_data.target_x;
    tgt[1] = in_data.target_y;
    tgt[2] = in_data.target_z;
    src[0] = in_data.source_x;
    src[1] = in_data.source_y;
    src[2] = in_data.source_z;
    sa_next = '0;
    for (int i = 0; i < 3; i++) begin
      d = {src[i][31], src[i]} - {tgt[i][31], tgt[i]};
      sa_next.neg[i] = d[DW-1];
      sa_next.mag[i] = d[DW-1] ? (~d + DW'(1)) : d;
    end
    sa_next.gm   = gravity * in_data.source_mass;
    sa_next.same = in_data.same_particle;
  end

  // Stage B: squares and the two halves of G * m * |D|.
  always_comb begin
    sb_next = '0;
    for (int i = 0; i < 3; i++) begin
      sb_next.sq[i] = sa.mag[i] * sa.mag[i];
      sb_next.pl[i] = sa.gm[GMW/2-1:0] * sa.mag[i];
      sb_next.ph[i] = sa.gm[GMW-1:GMW/2] * sa.mag[i];
    end
    sb_next.neg  = sa.neg;
    sb_next.same = sa.same;
  end

  // Stage C: softened r^2 and the numerators.
  always_comb begin
    logic [PRW-1:0] prod;
    sc_next = '0;
    sc_next.r2 = RW'(sb.sq[0]) + RW'(sb.sq[1]) + RW'(sb.sq[2])
               + (RW'(softening) << FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      prod = {sb.ph[i], {(GMW/2){1'b0}}} + PRW'(sb.pl[i]);
      sc_next.cy.num[i] = NUMW'(prod) << FRAC_BITS;
    end
    sc_next.cy.neg  = sb.neg;
    sc_next.cy.kill = sb.same;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa <= sa_next;
      sb <= sb_next;
      sc <= sc_next;
    end
  end

  // A zero softened distance forces a zero result like a self pair.
  always_comb begin
    ss_first         = '0;
    ss_first.rem     = sc.r2;
    ss_first.cy      = sc.cy;
    ss_first.cy.kill = sc.cy.kill || (sc.r2 == '0);
  end

  // Square root, one result bit per stage, keeping r^2 - res^2.
  for (genvar j = 0; j < QW; j++) begin : g_sqrt
    localparam int B = QW - 1 - j;
    st_s_t       cur, nxt;
    logic [RW:0] trial;
    if (j == 0) begin : g_first
      assign cur = ss_first;
    end else begin : g_rest
      assign cur = ss_reg[j-1];
    end
    always_comb begin
      nxt   = cur;
      trial = ((RW+1)'(cur.res) << (B + 1)) | ((RW+1)'(1) << (2 * B));
      if ({1'b0, cur.rem} >= trial) begin
        nxt.rem = RW'({1'b0, cur.rem} - trial);
        nxt.res = cur.res | (QW'(1) << B);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ss_reg[j] <= nxt;
      end
    end
  end

  // Cube of the distance: square, two partial products, then their sum.
  always_comb begin
    sq1_next    = '0;
    sq1_next.q  = ss_reg[QW-1].res;
    sq1_next.q2 = ss_reg[QW-1].res * ss_reg[QW-1].res;
    sq1_next.cy = ss_reg[QW-1].cy;
    sq2_next      = '0;
    sq2_next.p_lo = sq1.q2[QW-1:0] * sq1.q;
    sq2_next.p_hi = sq1.q2[Q2W-1:QW] * sq1.q;
    sq2_next.cy   = sq1.cy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq1     <= sq1_next;
      sq2     <= sq2_next;
      sq3.den <= DENW'(sq2.p_lo) + (DENW'(sq2.p_hi) << QW);
      sq3.cy  <= sq2.cy;
    end
  end

  // Divider entry: flag quotients too large for the kept bits.
  always_comb begin
    dv_first      = '0;
    dv_first.den  = sq3.den;
    dv_first.kill = sq3.cy.kill;
    dv_first.neg  = sq3.cy.neg;
    for (int i = 0; i < 3; i++) begin
      dv_first.rem[i] = WW'(sq3.cy.num[i]);
      dv_first.ovf[i] = WW'(sq3.cy.num[i]) >= (WW'(sq3.den) << QUW);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_reg[0] <= dv_first;
    end
  end

  // Restoring division, one quotient bit per stage on all three axes.
  for (genvar j = 0; j < QUW; j++) begin : g_div
    localparam int K = QUW - 1 - j;
    st_d_t         nxt;
    logic [WW-1:0] shifted;
    always_comb begin
      nxt     = dv_reg[j];
      shifted = WW'(dv_reg[j].den) << K;
      for (int i = 0; i < 3; i++) begin
        if (dv_reg[j].rem[i] >= shifted) begin
          nxt.rem[i]    = dv_reg[j].rem[i] - shifted;
          nxt.quo[i][K] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_reg[j+1] <= nxt;
      end
    end
  end

  // Sign, saturation and the zero cases.
  always_comb begin
    logic [31:0] ax [3];
    st_d_t       f;
    f = dv_reg[QUW];
    for (int i = 0; i < 3; i++) begin
      if (f.kill) begin
        ax[i] = '0;
      end else if (f.neg[i]) begin
        if (f.ovf[i] || (f.quo[i] > QUW'(33'h080000000))) begin
          ax[i] = 32'h80000000;
        end else begin
          ax[i] = 32'(~f.quo[i] + QUW'(1));
        end
      end else begin
        if (f.ovf[i] || (f.quo[i] > QUW'(33'h07FFFFFFF))) begin
          ax[i] = 32'h7FFFFFFF;
        end else begin
          ax[i] = f.quo[i][31:0];
        end
      end
    end
    res_item.accel_x = ax[0];
    res_item.accel_y = ax[1];
    res_item.accel_z = ax[2];
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || out_ready) begin
      ov <= sv || vld[NST-1];
      sv <= 1'b0;
    end else if (vld[NST-1] && !sv) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || out_ready) begin
      od <= sv ? sd : res_item;
    end else if (!sv) begin
      sd <= res_item;
    end
  end

  assign out_valid = ov;
  assign out_data  = od;

  // Checks.
  `ASSERT_HOLDS(a_skid_behind_out, sv |-> ov, "skid entry full while output empty")
  `ASSERT_HOLDS(a_hold_on_stall, !en |=> $stable(vld), "pipeline moved during a stall")
  `ASSERT_ALWAYS(a_reset_clears, rst |=> (vld == '0 && !ov && !sv), "reset left valid state")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Pairwise gravity acceleration testbench
// Streams target/source pairs through the block under several register
// settings and idle patterns, and checks every acceleration vector against a
// bit-exact softened-gravity predictor computed in wide integer arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import pga_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 75;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Idle percentages for each side.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Predictor copy of the two registers.
  logic [31:0] grav_g = '0;
  logic [31:0] soft_sq = 32'd655;

  out_item_t accel_queue[$];
  int errors = 0;
  int idle_cycles = 0;

  pairwise_gravity_acceleration_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Signed 32-bit component from a magnitude and sign, with saturation.
  function automatic logic [31:0] signed_saturate(logic [255:0] mag, logic neg);
    if (neg) begin
      if (mag > 256'h8000_0000) return 32'h8000_0000;
      return 32'(-mag[31:0]);
    end
    if (mag > 256'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // Softened acceleration vector for one pair.
  function automatic out_item_t gravity_accel(in_item_t p);
    logic signed [33:0] d[3];
    logic [33:0] mag[3];
    logic [127:0] r2;
    logic [127:0] q;
    logic [255:0] den;
    logic [255:0] num;
    logic [63:0] gm;
    logic [31:0] res[3];
    out_item_t o;
    d[0] = 34'(p.source_x) - 34'(p.target_x);
    d[1] = 34'(p.source_y) - 34'(p.target_y);
    d[2] = 34'(p.source_z) - 34'(p.target_z);
    o = '0;
    if (p.same_particle) return o;
    r2 = 128'(soft_sq) << FRAC;
    for (int i = 0; i < 3; i++) begin
      mag[i] = d[i][33] ? 34'(-d[i]) : 34'(d[i]);
      r2 += 128'(mag[i]) * 128'(mag[i]);
    end
    if (r2 == 0) return o;
    q = 0;
    for (int b = 35; b >= 0; b--)
      if ((q | (128'd1 << b)) * (q | (128'd1 << b)) <= r2) q |= 128'd1 << b;
    den = 256'(q) * 256'(q) * 256'(q);
    gm = 64'(grav_g) * 64'(p.source_mass);
    for (int i = 0; i < 3; i++) begin
      num = (256'(gm) * 256'(mag[i])) << FRAC;
      res[i] = signed_saturate(num / den, d[i][33]);
    end
    o.accel_x = res[0];
    o.accel_y = res[1];
    o.accel_z = res[2];
    return o;
  endfunction

  // Sends one pair and records its expected acceleration on transfer.
  // Valid stays high after the transfer; an idle gap in the next send or a drain drops it.
  task automatic send_pair(in_item_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accel_queue = {accel_queue, gravity_accel(p)};
    @(negedge clk);
  endtask

  // Waits for every pending result, then lets the pipeline drain.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (accel_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GRAVITY) grav_g = val;
    else soft_sq = val;
    @(negedge clk);
  endtask

  // Receiver stall pattern, changed at the falling edge.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Result checker and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
    if (!rst && out_valid && out_ready) begin
      if (accel_queue.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        out_item_t e;
        e = accel_queue.pop_front();
        if (out_data.accel_x !== e.accel_x) begin
          $error("accel_x expected %h actual %h", e.accel_x, out_data.accel_x);
          errors++;
        end
        if (out_data.accel_y !== e.accel_y) begin
          $error("accel_y expected %h actual %h", e.accel_y, out_data.accel_y);
          errors++;
        end
        if (out_data.accel_z !== e.accel_z) begin
          $error("accel_z expected %h actual %h", e.accel_z, out_data.accel_z);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(2000)) - 1000);
      3: return 32'(int'($urandom_range(1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_pair();
    in_item_t p;
    p.target_x = rand_word();
    p.target_y = rand_word();
    p.target_z = rand_word();
    // Mostly nearby sources so that accelerations land in range.
    if ($urandom_range(3) != 0) begin
      p.source_x = p.target_x + 32'(int'($urandom_range(1 << 18)) - (1 << 17));
      p.source_y = p.target_y + 32'(int'($urandom_range(1 << 18)) - (1 << 17));
      p.source_z = p.target_z + 32'(int'($urandom_range(1 << 18)) - (1 << 17));
    end else begin
      p.source_x = rand_word();
      p.source_y = rand_word();
      p.source_z = rand_word();
    end
    p.source_mass = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 18);
    p.same_particle = ($urandom_range(15) == 0);
    return p;
  endfunction

  function automatic in_item_t make_pair(logic [31:0] tx, logic [31:0] sx,
                                         logic [31:0] m, logic same);
    in_item_t p;
    p = '0;
    p.target_x = tx;
    p.source_x = sx;
    p.target_y = tx;
    p.source_y = sx;
    p.target_z = 32'd0;
    p.source_z = 32'd0;
    p.source_mass = m;
    p.same_particle = same;
    return p;
  endfunction

  // Extremes of fields, flags, zero distance and saturation.
  task automatic test_directed();
    write_reg(REG_GRAVITY, 32'h0001_0000);
    send_pair(make_pair(32'd0, 32'h0001_0000, 32'h0001_0000, 1'b0));
    send_pair(make_pair(32'd0, 32'h0001_0000, 32'h0001_0000, 1'b1));
    send_pair(make_pair(32'd5, 32'd5, 32'hFFFF_FFFF, 1'b0));
    send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
    send_pair(make_pair(32'd0, 32'd1, 32'hFFFF_FFFF, 1'b0));
    send_pair(make_pair(32'd1, 32'd0, 32'hFFFF_FFFF, 1'b0));
    send_pair(make_pair(32'hFFFF_FFFF, 32'h0000_0000, 32'd0, 1'b0));
    wait_drained();
    // Zero softening exposes the coincident-point case.
    write_reg(REG_SOFTENING, 32'd0);
    write_reg(REG_GRAVITY, 32'hFFFF_FFFF);
    send_pair(make_pair(32'd7, 32'd7, 32'hFFFF_FFFF, 1'b0));
    send_pair(make_pair(32'd0, 32'd1, 32'hFFFF_FFFF, 1'b0));
    send_pair(make_pair(32'd1, 32'd0, 32'hFFFF_FFFF, 1'b0));
    send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1'b0));
    send_pair(make_pair(32'h0010_0000, 32'd0, 32'h0000_0001, 1'b0));
    wait_drained();
    write_reg(REG_SOFTENING, 32'hFFFF_FFFF);
    send_pair(make_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0));
    send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    wait_drained();
  endtask

  // Random pairs under one register setting and one idle pattern.
  task automatic test_random(logic [31:0] g, logic [31:0] s, int n,
                             int send_pct, int recv_pct);
    write_reg(REG_GRAVITY, g);
    write_reg(REG_SOFTENING, s);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n; i++) begin
      send_pair(rand_pair());
      // Once per phase, let everything drain before continuing.
      if (i == n / 2) begin
        in_valid <= 1'b0;
        while (accel_queue.size() != 0) @(negedge clk);
        @(negedge clk);
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(32'h0001_0000, 32'd655, 300, 0, 0);
    test_random(32'h0000_0001, 32'd0, 250, 87, 0);
    test_random(32'h00AB_CDEF, 32'h0010_0000, 250, 0, 87);
    test_random(32'hFFFF_FFFF, 32'd1, 250, 27, 27);
    test_random($urandom, $urandom_range(1 << 20), 250, 0, 0);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/pga_pkg.sv
hdl/pairwise_gravity_acceleration_top.sv
bench/testbench.sv
